// File: rtl/whp_pkg.sv
// Shared types and constants for the WAV header parser.
package whp_pkg;

  // Input word: one file byte or an end marker
  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_marker;
  } in_t;

  // Result word: event code plus the held format values
  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  audio_byte;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [12:0] sample_bytes;
    logic        signed_samples;
    logic [31:0] audio_length;
  } out_t;

  // Parser phases
  typedef enum logic [3:0] {
    PH_PREAMBLE = 4'd0,
    PH_FSIZE    = 4'd1,
    PH_FBODY    = 4'd2,
    PH_CID      = 4'd3,
    PH_CLEN     = 4'd4,
    PH_CSKIP    = 4'd5,
    PH_DSIZE    = 4'd6,
    PH_AUDIO    = 4'd7,
    PH_DONE     = 4'd8
  } phase_e;

  // Event codes
  localparam logic [2:0] EV_HEADER     = 3'd0;
  localparam logic [2:0] EV_FMT_KNOWN  = 3'd1;
  localparam logic [2:0] EV_AUDIO      = 3'd2;
  localparam logic [2:0] EV_HDR_TRUNC  = 3'd3;
  localparam logic [2:0] EV_DATA_TRUNC = 3'd4;
  localparam logic [2:0] EV_COMPLETE   = 3'd5;
  localparam logic [2:0] EV_TRAILING   = 3'd6;

  // Header layout
  localparam logic [31:0] PREAMBLE_LEN = 32'd16;
  localparam logic [31:0] FIELD_LEN    = 32'd4;
  localparam logic [31:0] FMT_FULL_LEN = 32'd16;
  localparam logic [15:0] BITS_UNSIGNED = 16'd8;
  localparam logic [7:0]  LOWER_CASE   = 8'h20;

  // Lower-case "data" chunk id, one letter per position
  function automatic logic [7:0] data_id(input logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0: c = 8'h64;
      2'd1: c = 8'h61;
      2'd2: c = 8'h74;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  // Drop a byte into lane pos of a little-endian 32-bit word
  function automatic logic [31:0] put_le(input logic [31:0] acc, input logic [7:0] b,
                                         input logic [1:0] pos);
    logic [31:0] r;
    r = acc;
    unique case (pos)
      2'd0: r[7:0]   = acc[7:0]   | b;
      2'd1: r[15:8]  = acc[15:8]  | b;
      2'd2: r[23:16] = acc[23:16] | b;
      default: r[31:24] = acc[31:24] | b;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/wav_header_parser_core.sv
// Top level of the WAV header parser: input register, parser, result register.
//
// Usage:
//   Feed the file one byte per word on the input channel (in_valid_i,
//   in_ready_o, in_data_i). After the last byte send a word with end_marker
//   set; its file_byte is ignored. Every input word yields exactly one result
//   word on the output channel (out_valid_o, out_ready_i, out_data_o): an
//   event code, the audio byte when the event is audio, and the format and
//   data-size values as held after that word.
//   Path: an accepted word is registered in the input register, parsed,
//   then registered in the result register, from which out_valid_o shows it.
//   Throughput: one word per cycle while out_ready_i keeps the result register free.
//   Reset: rst_ni clears both registers and returns the parser to the start
//   of the RIFF tag with all held values zero. An end marker does the same
//   after its result is formed.
//   Stall: when out_ready_i is low the result register holds, the input
//   register fills behind it and then in_ready_o drops; nothing is lost.
module wav_header_parser_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  whp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output whp_pkg::out_t out_data_o
);

  logic          stage_valid;
  whp_pkg::in_t  stage_data;
  logic          out_space;
  logic          fire;
  whp_pkg::out_t result;

  // Parse the registered word when the result register can take it
  assign fire = stage_valid && out_space;

  whp_input_stage u_input (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (fire),
    .valid_o    (stage_valid),
    .data_o     (stage_data)
  );

  whp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (stage_data),
    .result_o (result)
  );

  whp_output_stage u_output (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .data_i      (result),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: rtl/whp_input_stage.sv
// Input register that captures one word per cycle from the upstream channel while the held word moves on.
module whp_input_stage (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  whp_pkg::in_t in_data_i,
  input  logic         advance_i,
  output logic         valid_o,
  output whp_pkg::in_t data_o
);

  logic         valid_q;
  whp_pkg::in_t data_q;

  // Take a new word when empty or when the held word moves on
  assign in_ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Hold payload until replaced
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= in_data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/whp_parser.sv
// Parser state registers and the per-word next-state and result logic.
module whp_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  whp_pkg::in_t  item_i,
  output whp_pkg::out_t result_o
);

  whp_pkg::phase_e phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [31:0] fmt_len_q, fmt_len_d;
  logic [31:0] chunk_len_q, chunk_len_d;
  logic        mismatch_q, mismatch_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] total_q, total_d;

  logic [31:0] cnt_inc;
  logic [31:0] remain_dec;
  logic [7:0]  b;
  logic [2:0]  ev;
  logic [7:0]  abyte;
  logic [15:0] bits_eff;

  assign cnt_inc    = cnt_q + 32'd1;
  assign remain_dec = remain_q - 32'd1;
  assign b          = item_i.file_byte;

  // Advance the parser by one word
  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    fmt_len_d   = fmt_len_q;
    chunk_len_d = chunk_len_q;
    mismatch_d  = mismatch_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    bits_d      = bits_q;
    remain_d    = remain_q;
    total_d     = total_q;
    ev          = whp_pkg::EV_HEADER;
    abyte       = 8'd0;
    if (item_i.end_marker) begin
      priority if (phase_q == whp_pkg::PH_AUDIO) begin
        ev = whp_pkg::EV_DATA_TRUNC;
      end else if (phase_q == whp_pkg::PH_DONE) begin
        ev = whp_pkg::EV_COMPLETE;
      end else begin
        ev = whp_pkg::EV_HDR_TRUNC;
      end
    end else begin
      unique case (phase_q)
        whp_pkg::PH_PREAMBLE: begin
          cnt_d = cnt_inc;
          if (cnt_inc == whp_pkg::PREAMBLE_LEN) begin
            cnt_d   = 32'd0;
            phase_d = whp_pkg::PH_FSIZE;
          end
        end
        whp_pkg::PH_FSIZE: begin
          fmt_len_d = whp_pkg::put_le(fmt_len_q, b, cnt_q[1:0]);
          cnt_d     = cnt_inc;
          if (cnt_inc == whp_pkg::FIELD_LEN) begin
            cnt_d  = 32'd0;
            chan_d = 16'd0;
            rate_d = 32'd0;
            bits_d = 16'd0;
            if (fmt_len_d == 32'd0) begin
              ev         = whp_pkg::EV_FMT_KNOWN;
              phase_d    = whp_pkg::PH_CID;
              mismatch_d = 1'b0;
            end else begin
              phase_d = whp_pkg::PH_FBODY;
            end
          end
        end
        whp_pkg::PH_FBODY: begin
          // Capture channels, rate and bits at their offsets
          if (cnt_q == 32'd2) begin
            chan_d[7:0] = chan_q[7:0] | b;
          end else if (cnt_q == 32'd3) begin
            chan_d[15:8] = chan_q[15:8] | b;
          end else if (cnt_q >= 32'd4 && cnt_q <= 32'd7) begin
            rate_d = whp_pkg::put_le(rate_q, b, cnt_q[1:0]);
          end else if (cnt_q == 32'd14) begin
            bits_d[7:0] = bits_q[7:0] | b;
          end else if (cnt_q == 32'd15) begin
            bits_d[15:8] = bits_q[15:8] | b;
          end
          cnt_d = cnt_inc;
          if (cnt_inc == fmt_len_q) begin
            ev         = whp_pkg::EV_FMT_KNOWN;
            cnt_d      = 32'd0;
            mismatch_d = 1'b0;
            phase_d    = whp_pkg::PH_CID;
          end
        end
        whp_pkg::PH_CID: begin
          mismatch_d = mismatch_q ||
                       ((b | whp_pkg::LOWER_CASE) != whp_pkg::data_id(cnt_q[1:0]));
          cnt_d = cnt_inc;
          if (cnt_inc == whp_pkg::FIELD_LEN) begin
            cnt_d       = 32'd0;
            chunk_len_d = 32'd0;
            total_d     = 32'd0;
            phase_d     = mismatch_d ? whp_pkg::PH_CLEN : whp_pkg::PH_DSIZE;
            mismatch_d  = 1'b0;
          end
        end
        whp_pkg::PH_CLEN: begin
          chunk_len_d = whp_pkg::put_le(chunk_len_q, b, cnt_q[1:0]);
          cnt_d       = cnt_inc;
          if (cnt_inc == whp_pkg::FIELD_LEN) begin
            cnt_d   = 32'd0;
            phase_d = (chunk_len_d == 32'd0) ? whp_pkg::PH_CID : whp_pkg::PH_CSKIP;
          end
        end
        whp_pkg::PH_CSKIP: begin
          cnt_d = cnt_inc;
          if (cnt_inc == chunk_len_q) begin
            cnt_d   = 32'd0;
            phase_d = whp_pkg::PH_CID;
          end
        end
        whp_pkg::PH_DSIZE: begin
          total_d = whp_pkg::put_le(total_q, b, cnt_q[1:0]);
          cnt_d   = cnt_inc;
          if (cnt_inc == whp_pkg::FIELD_LEN) begin
            cnt_d    = 32'd0;
            remain_d = total_d;
            phase_d  = (total_d == 32'd0) ? whp_pkg::PH_DONE : whp_pkg::PH_AUDIO;
          end
        end
        whp_pkg::PH_AUDIO: begin
          ev       = whp_pkg::EV_AUDIO;
          abyte    = b;
          remain_d = remain_dec;
          if (remain_dec == 32'd0) begin
            phase_d = whp_pkg::PH_DONE;
          end
        end
        default: begin
          ev      = whp_pkg::EV_TRAILING;
          phase_d = whp_pkg::PH_DONE;
        end
      endcase
    end
  end

  // Report the values as they stand after this word
  assign bits_eff = (fmt_len_d >= whp_pkg::FMT_FULL_LEN) ? bits_d : 16'd0;

  always_comb begin
    result_o.event_res      = ev;
    result_o.audio_byte     = abyte;
    result_o.channel_count  = chan_d;
    result_o.sample_rate    = rate_d;
    result_o.sample_bits    = bits_eff;
    result_o.sample_bytes   = bits_eff[15:3];
    result_o.signed_samples = (bits_eff != whp_pkg::BITS_UNSIGNED);
    result_o.audio_length   = total_d;
  end

  // Update state; an end marker returns everything to its start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= whp_pkg::PH_PREAMBLE;
      cnt_q       <= 32'd0;
      fmt_len_q   <= 32'd0;
      chunk_len_q <= 32'd0;
      mismatch_q  <= 1'b0;
      chan_q      <= 16'd0;
      rate_q      <= 32'd0;
      bits_q      <= 16'd0;
      remain_q    <= 32'd0;
      total_q     <= 32'd0;
    end else if (fire_i) begin
      if (item_i.end_marker) begin
        phase_q     <= whp_pkg::PH_PREAMBLE;
        cnt_q       <= 32'd0;
        fmt_len_q   <= 32'd0;
        chunk_len_q <= 32'd0;
        mismatch_q  <= 1'b0;
        chan_q      <= 16'd0;
        rate_q      <= 32'd0;
        bits_q      <= 16'd0;
        remain_q    <= 32'd0;
        total_q     <= 32'd0;
      end else begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        fmt_len_q   <= fmt_len_d;
        chunk_len_q <= chunk_len_d;
        mismatch_q  <= mismatch_d;
        chan_q      <= chan_d;
        rate_q      <= rate_d;
        bits_q      <= bits_d;
        remain_q    <= remain_d;
        total_q     <= total_d;
      end
    end
  end

  // An end marker always sends the parser back to the preamble
  a_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.end_marker |=> phase_q == whp_pkg::PH_PREAMBLE && cnt_q == 32'd0)
    else $error("parser did not restart after end marker");

  // Audio phase always has bytes still due
  a_audio_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == whp_pkg::PH_AUDIO |-> remain_q != 32'd0)
    else $error("audio phase with no bytes remaining");

  // Audio events come only from the audio phase
  a_audio_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.event_res == whp_pkg::EV_AUDIO |-> phase_q == whp_pkg::PH_AUDIO)
    else $error("audio event outside audio phase");

  // Preamble and fixed fields never overrun their lengths
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == whp_pkg::PH_PREAMBLE && cnt_q < whp_pkg::PREAMBLE_LEN) ||
    ((phase_q == whp_pkg::PH_FSIZE || phase_q == whp_pkg::PH_CID ||
      phase_q == whp_pkg::PH_CLEN || phase_q == whp_pkg::PH_DSIZE) &&
     cnt_q < whp_pkg::FIELD_LEN) ||
    phase_q == whp_pkg::PH_FBODY || phase_q == whp_pkg::PH_CSKIP ||
    phase_q == whp_pkg::PH_AUDIO || phase_q == whp_pkg::PH_DONE)
    else $error("byte counter out of range");

endmodule

// File: rtl/whp_output_stage.sv
// Result register that holds one word for the downstream channel.
module whp_output_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  whp_pkg::out_t data_i,
  output logic          space_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output whp_pkg::out_t out_data_o
);

  logic          valid_q;
  whp_pkg::out_t data_q;

  // Free when empty or when the held word is taken this cycle
  assign space_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (space_o) begin
      valid_q <= load_i;
    end
  end

  // Hold result until replaced
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
